[rtl/qaud_pkg.sv]
// Package for the query argument extract and URL decode unit.
// Holds the phase encoding, register indexes, character codes and the result type.
// No dependencies.
package qaud_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned LEN_W      = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_TEXT    = 2'd0,
    CFG_KEY_LENGTH  = 2'd1,
    CFG_VALUE_LIMIT = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    PH_SEG   = 3'd0,
    PH_MATCH = 3'd1,
    PH_SKIP  = 3'd2,
    PH_VALUE = 3'd3,
    PH_DONE  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    ESC_NONE = 2'd0,
    ESC_HIGH = 2'd1,
    ESC_LOW  = 2'd2
  } esc_step_t;

  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [LEN_W-1:0] VALUE_LIMIT_RST = 12'd64;

  typedef struct packed {
    logic             kind;
    logic [7:0]       byte_value;
    logic             found;
    logic [LEN_W-1:0] value_length;
    logic             run_last;
  } result_t;

  function automatic logic [3:0] hex_digit(input logic [7:0] b);
    logic [3:0] d;
    d = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      d = 4'(b - 8'h30);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      d = 4'(b - 8'h37);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      d = 4'(b - 8'h57);
    end
    return d;
  endfunction

endpackage

[rtl/qaud_if.sv]
// Valid/ready channel interfaces for the query argument extract unit.
// Depends on qaud_pkg for the result length width.
interface qaud_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       end_of_string;

  modport source (output valid, output byte_in, output end_of_string, input ready);
  modport sink   (input valid, input byte_in, input end_of_string, output ready);
endinterface

interface qaud_out_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [7:0]                 byte_value;
  logic                       found;
  logic [qaud_pkg::LEN_W-1:0] value_length;
  logic                       run_last;

  modport source (output valid, output kind, output byte_value, output found,
                  output value_length, output run_last, input ready);
  modport sink   (input valid, input kind, input byte_value, input found,
                  input value_length, input run_last, output ready);
endinterface

[rtl/query_arg_extract_url_decode_unit.sv]
// Query string key lookup with URL decoding of the matching value.
// Results are registered; an input beat's first result beat is offered in the next cycle.
// Throughput: one input beat per cycle while the output is not stalled; a beat that
// yields two results (a value byte and its completion) holds the input until the first
// is taken, as the two-entry result register drains one beat per cycle when ready.
// Reset: synchronous, clears the parse state, empties the result register
// and loads the register defaults (value limit 64).
module query_arg_extract_url_decode_unit #(
  parameter int unsigned KEY_BYTES = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [qaud_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [qaud_pkg::CFG_DATA_W-1:0]  cfg_data,
  qaud_in_if.sink                          in_chan,
  qaud_out_if.source                       out_chan
);
  import qaud_pkg::*;

  localparam int unsigned KEY_W = KEY_BYTES * 8;

  logic [KEY_W-1:0] key_r;
  logic [3:0]       key_len_r;
  logic [LEN_W-1:0] limit_r;

  phase_t           phase_r, phase_nxt;
  logic [3:0]       key_pos_r, key_pos_nxt;
  esc_step_t        esc_step_r, esc_step_nxt;
  logic [3:0]       esc_high_r, esc_high_nxt;
  logic [LEN_W-1:0] emit_cnt_r, emit_cnt_nxt;

  result_t          q_r [2];
  result_t          q_nxt [2];
  logic [1:0]       q_cnt_r, q_cnt_nxt;

  result_t          res [2];
  logic [1:0]       res_n;

  logic             accept;
  logic             pop;
  logic [3:0]       klen;
  logic [7:0]       kb;
  logic [7:0]       b;
  logic             last;
  logic             emit_b;
  logic [7:0]       emit_val;
  logic             cpl;
  logic             cpl_found;
  logic [LEN_W-1:0] cpl_len;
  logic             seg_end;

  assign klen = (key_len_r > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : key_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r     <= '0;
      key_len_r <= '0;
      limit_r   <= VALUE_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KEY_TEXT:    key_r     <= cfg_data[KEY_W-1:0];
        CFG_KEY_LENGTH:  key_len_r <= cfg_data[3:0];
        CFG_VALUE_LIMIT: limit_r   <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign b      = in_chan.byte_in;
  assign last   = in_chan.end_of_string;
  assign pop    = out_chan.valid && out_chan.ready;
  assign in_chan.ready = (q_cnt_r == 2'd0) || (q_cnt_r == 2'd1 && out_chan.ready);
  assign accept = in_chan.valid && in_chan.ready;

  always_comb begin
    phase_nxt    = phase_r;
    key_pos_nxt  = key_pos_r;
    esc_step_nxt = esc_step_r;
    esc_high_nxt = esc_high_r;
    emit_cnt_nxt = emit_cnt_r;
    kb           = 8'd0;
    emit_b       = 1'b0;
    emit_val     = 8'd0;
    cpl          = 1'b0;
    cpl_found    = 1'b0;
    cpl_len      = '0;
    seg_end      = 1'b0;

    if (b != CH_NUL) begin
      if (phase_nxt == PH_SEG) begin
        if (b == CH_CR || b == CH_LF) begin
          cpl       = 1'b1;
          phase_nxt = PH_DONE;
          seg_end   = 1'b1;
        end else begin
          phase_nxt   = PH_MATCH;
          key_pos_nxt = 4'd0;
        end
      end
      if (!seg_end) begin
        unique case (phase_nxt)
          PH_MATCH: begin
            if (b == CH_AMP) begin
              phase_nxt   = PH_SEG;
              key_pos_nxt = 4'd0;
            end else if (key_pos_nxt < klen) begin
              kb = 8'(key_r >> {key_pos_nxt[2:0], 3'b000});
              if (b == kb) begin
                key_pos_nxt = key_pos_nxt + 4'd1;
              end else begin
                phase_nxt = PH_SKIP;
              end
            end else if (b == CH_EQ) begin
              phase_nxt    = PH_VALUE;
              esc_step_nxt = ESC_NONE;
              esc_high_nxt = 4'd0;
              emit_cnt_nxt = '0;
              if (limit_r == '0) begin
                cpl       = 1'b1;
                cpl_found = 1'b1;
                phase_nxt = PH_DONE;
              end
            end else begin
              phase_nxt = PH_SKIP;
            end
          end
          PH_SKIP: begin
            if (b == CH_AMP) begin
              phase_nxt   = PH_SEG;
              key_pos_nxt = 4'd0;
            end
          end
          PH_VALUE: begin
            if (b == CH_AMP || emit_cnt_nxt >= limit_r) begin
              cpl       = 1'b1;
              cpl_found = 1'b1;
              cpl_len   = emit_cnt_nxt;
              phase_nxt = PH_DONE;
            end else if (esc_step_nxt == ESC_HIGH) begin
              esc_high_nxt = hex_digit(b);
              esc_step_nxt = ESC_LOW;
            end else if (esc_step_nxt == ESC_LOW) begin
              esc_step_nxt = ESC_NONE;
              emit_b       = 1'b1;
              emit_val     = {esc_high_nxt, hex_digit(b)};
            end else if (b == CH_PCT) begin
              esc_step_nxt = ESC_HIGH;
            end else if (b == CH_PLUS) begin
              emit_b   = 1'b1;
              emit_val = CH_SPACE;
            end else begin
              emit_b   = 1'b1;
              emit_val = b;
            end
            if (emit_b) begin
              emit_cnt_nxt = emit_cnt_nxt + 1'b1;
              if (emit_cnt_nxt >= limit_r) begin
                cpl       = 1'b1;
                cpl_found = 1'b1;
                cpl_len   = emit_cnt_nxt;
                phase_nxt = PH_DONE;
              end
            end
          end
          default: ;
        endcase
      end
    end

    if (b == CH_NUL || last) begin
      if (phase_nxt != PH_DONE) begin
        cpl       = 1'b1;
        cpl_found = (phase_nxt == PH_VALUE);
        cpl_len   = (phase_nxt == PH_VALUE) ? emit_cnt_nxt : '0;
      end
      phase_nxt    = PH_SEG;
      key_pos_nxt  = 4'd0;
      esc_step_nxt = ESC_NONE;
      esc_high_nxt = 4'd0;
      emit_cnt_nxt = '0;
    end
  end

  always_comb begin
    res[0] = '0;
    res[1] = '0;
    res_n  = 2'd0;
    if (emit_b) begin
      res[0].byte_value = emit_val;
      if (cpl) begin
        res[1].kind         = 1'b1;
        res[1].found        = cpl_found;
        res[1].value_length = cpl_len;
        res[1].run_last     = 1'b1;
        res_n               = 2'd2;
      end else begin
        res[0].run_last = 1'b1;
        res_n           = 2'd1;
      end
    end else if (cpl) begin
      res[0].kind         = 1'b1;
      res[0].found        = cpl_found;
      res[0].value_length = cpl_len;
      res[0].run_last     = 1'b1;
      res_n               = 2'd1;
    end
  end

  always_comb begin
    q_nxt[0]  = q_r[0];
    q_nxt[1]  = q_r[1];
    q_cnt_nxt = q_cnt_r;
    if (accept) begin
      q_nxt[0]  = res[0];
      q_nxt[1]  = res[1];
      q_cnt_nxt = res_n;
    end else if (pop) begin
      q_nxt[0]  = q_r[1];
      q_cnt_nxt = q_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_SEG;
      key_pos_r  <= 4'd0;
      esc_step_r <= ESC_NONE;
      esc_high_r <= 4'd0;
      emit_cnt_r <= '0;
      q_cnt_r    <= 2'd0;
    end else begin
      if (accept) begin
        phase_r    <= phase_nxt;
        key_pos_r  <= key_pos_nxt;
        esc_step_r <= esc_step_nxt;
        esc_high_r <= esc_high_nxt;
        emit_cnt_r <= emit_cnt_nxt;
      end
      q_cnt_r <= q_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r[0] <= q_nxt[0];
    q_r[1] <= q_nxt[1];
  end

  assign out_chan.valid        = (q_cnt_r != 2'd0);
  assign out_chan.kind         = q_r[0].kind;
  assign out_chan.byte_value   = q_r[0].byte_value;
  assign out_chan.found        = q_r[0].found;
  assign out_chan.value_length = q_r[0].value_length;
  assign out_chan.run_last     = q_r[0].run_last;

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// Testbench for query_arg_extract_url_decode_unit: key lookup and URL decoding of query strings.
// Predicts every result beat from a shadow of the registers and parse state, checks each beat.
// Depends on qaud_pkg and the qaud_in_if / qaud_out_if interfaces.
module tb;
  import qaud_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_PHASES = 7;
  localparam int PHASE_BEATS   = 70;

  typedef logic [7:0] byte_q_t[$];
  typedef enum logic [1:0] {TERM_FLAG, TERM_NUL, TERM_NONE} term_t;
  typedef enum logic [1:0] {STALL_NONE, STALL_HALF, STALL_HEAVY, STALL_LIGHT} stall_mode_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  qaud_in_if  in_chan ();
  qaud_out_if out_chan ();

  query_arg_extract_url_decode_unit #(.KEY_BYTES(8)) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  logic [63:0]      key_text_sh;
  logic [3:0]       key_len_sh;
  logic [LEN_W-1:0] limit_sh;

  phase_t           scan_phase;
  logic [3:0]       scan_key_pos;
  esc_step_t        scan_esc;
  logic [3:0]       scan_esc_hi;
  logic [LEN_W-1:0] scan_emitted;

  result_t beat_results[$];
  result_t results_owed[$];
  result_t owed;

  int    err_count    = 0;
  int    cycle_count  = 0;
  int    beats_sent   = 0;
  int    burst_left   = 0;
  int    hold_request = 0;
  bit    steady_send  = 1'b0;
  string hex_chars    = "0123456789abcdefABCDEF";

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    err_count++;
  endfunction

  function automatic void check_field(input string name, input logic [LEN_W-1:0] got,
                                      input logic [LEN_W-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    end
  endfunction

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return c[3:0];
    if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) return c[3:0] + 4'd9;
    return 4'd0;
  endfunction

  function automatic void add_result(input logic kind, input logic [7:0] value,
                                     input logic fnd, input logic [LEN_W-1:0] len);
    result_t r;
    r.kind         = kind;
    r.byte_value   = value;
    r.found        = fnd;
    r.value_length = len;
    r.run_last     = 1'b0;
    beat_results.push_back(r);
  endfunction

  function automatic void finish_value(input logic fnd);
    add_result(1'b1, 8'h00, fnd, fnd ? scan_emitted : '0);
    scan_phase = PH_DONE;
  endfunction

  function automatic void emit_decoded(input logic [7:0] b);
    add_result(1'b0, b, 1'b0, '0);
    scan_emitted = scan_emitted + 1'b1;
    if (scan_emitted >= limit_sh) finish_value(1'b1);
  endfunction

  function automatic void clear_scan();
    scan_phase   = PH_SEG;
    scan_key_pos = '0;
    scan_esc     = ESC_NONE;
    scan_esc_hi  = '0;
    scan_emitted = '0;
  endfunction

  function automatic void scan_content(input logic [7:0] b);
    logic [3:0] klen;
    klen = (key_len_sh > 4'd8) ? 4'd8 : key_len_sh;
    if (scan_phase == PH_SEG) begin
      if (b == CH_CR || b == CH_LF) begin
        finish_value(1'b0);
        return;
      end
      scan_phase   = PH_MATCH;
      scan_key_pos = '0;
    end
    case (scan_phase)
      PH_MATCH: begin
        if (b == CH_AMP) begin
          scan_phase   = PH_SEG;
          scan_key_pos = '0;
        end else if (scan_key_pos < klen) begin
          if (b == key_text_sh[{scan_key_pos[2:0], 3'b000} +: 8]) scan_key_pos++;
          else scan_phase = PH_SKIP;
        end else if (b == CH_EQ) begin
          scan_phase   = PH_VALUE;
          scan_esc     = ESC_NONE;
          scan_esc_hi  = '0;
          scan_emitted = '0;
          if (scan_emitted >= limit_sh) finish_value(1'b1);
        end else begin
          scan_phase = PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (b == CH_AMP) begin
          scan_phase   = PH_SEG;
          scan_key_pos = '0;
        end
      end
      PH_VALUE: begin
        if (b == CH_AMP || scan_emitted >= limit_sh) begin
          finish_value(1'b1);
        end else if (scan_esc == ESC_HIGH) begin
          scan_esc_hi = nibble_of(b);
          scan_esc    = ESC_LOW;
        end else if (scan_esc == ESC_LOW) begin
          scan_esc = ESC_NONE;
          emit_decoded({scan_esc_hi, nibble_of(b)});
        end else if (b == CH_PCT) begin
          scan_esc = ESC_HIGH;
        end else if (b == CH_PLUS) begin
          emit_decoded(CH_SPACE);
        end else begin
          emit_decoded(b);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void parse_query_byte(input logic [7:0] b, input logic eos);
    beat_results.delete();
    if (b != CH_NUL) scan_content(b);
    if (b == CH_NUL || eos) begin
      if (scan_phase != PH_DONE) finish_value(scan_phase == PH_VALUE);
      clear_scan();
    end
    if (beat_results.size() > 0) beat_results[beat_results.size()-1].run_last = 1'b1;
    foreach (beat_results[i]) results_owed.push_back(beat_results[i]);
  endfunction

  function automatic byte_q_t bytes_of(input string txt);
    byte_q_t q;
    for (int i = 0; i < txt.len(); i++) q.push_back(txt[i]);
    return q;
  endfunction

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_KEY_TEXT:    key_text_sh = data;
      CFG_KEY_LENGTH:  key_len_sh  = data[3:0];
      CFG_VALUE_LIMIT: limit_sh    = data[LEN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic send_beat(input logic [7:0] b, input logic eos);
    int gap;
    if (!steady_send) begin
      if (burst_left == 0) begin
        gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        burst_left = $urandom_range(1, 16);
        if (gap > 0) begin
          in_chan.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
    end
    in_chan.valid         <= 1'b1;
    in_chan.byte_in       <= b;
    in_chan.end_of_string <= eos;
    do @(posedge clk); while (!in_chan.ready);
    parse_query_byte(b, eos);
    beats_sent++;
  endtask

  task automatic send_query(input byte_q_t s, input term_t term);
    foreach (s[i]) send_beat(s[i], term == TERM_FLAG && i == s.size() - 1);
    if (term == TERM_NUL || (term == TERM_FLAG && s.size() == 0)) send_beat(CH_NUL, 1'b0);
  endtask

  // drop valid, drain all owed results, then let in-flight beats settle
  task automatic wait_idle();
    in_chan.valid <= 1'b0;
    while (results_owed.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    byte_q_t q;
    q = bytes_of("=");
    q.push_back(8'hFF);
    send_query(q, TERM_FLAG);
    wait_idle();
  endtask

  task automatic test_key_edges();
    write_reg(CFG_KEY_TEXT, {48'h0, "&", "k"});
    write_reg(CFG_KEY_LENGTH, 64'd2);
    send_query(bytes_of("k&"), TERM_FLAG);
    wait_idle();
    write_reg(CFG_KEY_LENGTH, 64'd1);
    send_query(bytes_of("\n"), TERM_FLAG);
    send_query(bytes_of("\r"), TERM_FLAG);
    send_query(bytes_of(""), TERM_NUL);
    wait_idle();
  endtask

  task automatic test_limit_extremes();
    write_reg(CFG_VALUE_LIMIT, 64'd0);
    send_query(bytes_of("k="), TERM_FLAG);
    wait_idle();
    write_reg(CFG_VALUE_LIMIT, 64'd4095);
    send_query(bytes_of("k=%F"), TERM_FLAG);
    wait_idle();
    write_reg(CFG_VALUE_LIMIT, 64'd1);
    send_query(bytes_of("k=%zz"), TERM_FLAG);
    wait_idle();
  endtask

  task automatic test_limit_lowered();
    write_reg(CFG_VALUE_LIMIT, 64'd64);
    send_query(bytes_of("x&k=%4a+"), TERM_NONE);
    wait_idle();
    write_reg(CFG_VALUE_LIMIT, 64'd1);
    send_query(bytes_of("z"), TERM_NUL);
    wait_idle();
  endtask

  task automatic test_backpressure();
    byte_q_t    q;
    logic [7:0] c;
    write_reg(CFG_KEY_TEXT, {56'h0, "v"});
    write_reg(CFG_KEY_LENGTH, 64'd1);
    write_reg(CFG_VALUE_LIMIT, 64'd4095);
    q = bytes_of("v=");
    repeat (150) begin
      c = 8'($urandom_range(8'h21, 8'h7E));
      q.push_back((c == CH_AMP || c == CH_PCT) ? "Q" : c);
    end
    steady_send  = 1'b1;
    hold_request = 300;
    send_query(q, TERM_FLAG);
    steady_send = 1'b0;
    wait_idle();
  endtask

  function automatic logic [7:0] random_key_byte();
    int r;
    r = $urandom_range(0, 39);
    if (r == 0) return 8'h00;
    if (r <= 3) return 8'($urandom_range(1, 255));
    return 8'("a" + $urandom_range(0, 25));
  endfunction

  task automatic configure_random();
    logic [63:0]      key;
    logic [3:0]       klen;
    logic [LEN_W-1:0] lim;
    int               n;
    for (int i = 0; i < 8; i++) key[8*i +: 8] = random_key_byte();
    n = $urandom_range(0, 19);
    if (n < 2) klen = 4'd0;
    else if (n < 17) klen = 4'($urandom_range(1, 8));
    else klen = 4'($urandom_range(9, 15));
    case ($urandom_range(0, 9))
      0:       lim = 12'd0;
      1:       lim = 12'd1;
      2:       lim = 12'($urandom_range(2, 6));
      3:       lim = 12'd4095;
      default: lim = 12'($urandom_range(7, 64));
    endcase
    write_reg(CFG_KEY_TEXT, key);
    write_reg(CFG_KEY_LENGTH, {$urandom, 28'($urandom), klen});
    write_reg(CFG_VALUE_LIMIT, {$urandom, 20'($urandom), lim});
  endtask

  task automatic append_value(ref byte_q_t q);
    int len;
    len = $urandom_range(0, 12);
    repeat (len) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3: begin
          q.push_back(CH_PCT);
          q.push_back(hex_chars[$urandom_range(0, 21)]);
          q.push_back(hex_chars[$urandom_range(0, 21)]);
        end
        4: begin
          q.push_back(CH_PCT);
          q.push_back(8'($urandom_range(1, 255)));
          q.push_back(8'($urandom_range(1, 255)));
        end
        5, 6:    q.push_back(CH_PLUS);
        7:       q.push_back(8'($urandom_range(1, 255)));
        default: q.push_back(8'($urandom_range(8'h20, 8'h7E)));
      endcase
    end
    // leave an escape open now and then
    if ($urandom_range(0, 7) == 0) begin
      q.push_back(CH_PCT);
      if ($urandom_range(0, 1)) q.push_back(hex_chars[$urandom_range(0, 21)]);
    end
  endtask

  task automatic append_segment(ref byte_q_t q);
    int         eff;
    int         cut;
    logic [7:0] kb;
    eff = (key_len_sh > 4'd8) ? 8 : key_len_sh;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6, 7: begin
        for (int i = 0; i < eff; i++) q.push_back(key_text_sh[8*i +: 8]);
        q.push_back(CH_EQ);
        append_value(q);
      end
      8, 9, 10: begin
        if (eff > 0) begin
          cut = $urandom_range(0, eff - 1);
          for (int i = 0; i < cut; i++) q.push_back(key_text_sh[8*i +: 8]);
          kb = key_text_sh[8*cut +: 8];
          q.push_back(kb ^ (8'h01 << $urandom_range(0, 7)));
        end
        q.push_back(CH_EQ);
        append_value(q);
      end
      11, 12: begin
        repeat ($urandom_range(0, 4)) q.push_back(8'("a" + $urandom_range(0, 25)));
        q.push_back(CH_EQ);
        append_value(q);
      end
      13, 14: begin
        for (int i = 0; i < eff; i++) q.push_back(key_text_sh[8*i +: 8]);
        if ($urandom_range(0, 1)) q.push_back(8'("a" + $urandom_range(0, 25)));
      end
      15: begin
        q.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
        repeat ($urandom_range(0, 3)) q.push_back(8'("a" + $urandom_range(0, 25)));
      end
      default: begin
        repeat ($urandom_range(1, 6)) q.push_back(8'($urandom_range(0, 255)));
      end
    endcase
  endtask

  task automatic send_random_query();
    byte_q_t q;
    term_t   term;
    int      segs;
    int      r;
    segs = $urandom_range(1, 4);
    for (int s = 0; s < segs; s++) begin
      if (s > 0) q.push_back(CH_AMP);
      append_segment(q);
    end
    r = $urandom_range(0, 9);
    if (r <= 4) begin
      term = TERM_FLAG;
    end else if (r <= 8) begin
      term = TERM_NUL;
    end else begin
      term = TERM_FLAG;
      repeat ($urandom_range(1, 3)) begin
        if (q.size() > 1) void'(q.pop_back());
      end
    end
    send_query(q, term);
  endtask

  task automatic test_random_queries();
    int start;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      configure_random();
      steady_send = ($urandom_range(0, 3) == 0);
      start       = beats_sent;
      while (beats_sent - start < PHASE_BEATS) send_random_query();
      steady_send = 1'b0;
      wait_idle();
    end
  endtask

  initial begin : receiver
    int          hold_left;
    int          mode_left;
    stall_mode_t mode;
    out_chan.ready = 1'b0;
    hold_left      = 0;
    mode_left      = 0;
    mode           = STALL_NONE;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (mode_left == 0) begin
        mode      = stall_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      if (hold_left > 0) begin
        out_chan.ready <= 1'b0;
        hold_left--;
      end else begin
        case (mode)
          STALL_NONE:  out_chan.ready <= 1'b1;
          STALL_HALF:  out_chan.ready <= 1'($urandom_range(0, 1));
          STALL_HEAVY: out_chan.ready <= ($urandom_range(0, 3) == 0);
          default:     out_chan.ready <= ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (results_owed.size() == 0) begin
        report_mismatch($sformatf("unexpected beat kind=%0d byte=%02h",
                                  out_chan.kind, out_chan.byte_value));
      end else begin
        owed = results_owed.pop_front();
        check_field("kind", out_chan.kind, owed.kind);
        check_field("byte_value", out_chan.byte_value, owed.byte_value);
        check_field("found", out_chan.found, owed.found);
        check_field("value_length", out_chan.value_length, owed.value_length);
        check_field("run_last", out_chan.run_last, owed.run_last);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles, %0d results owed", cycle_count, results_owed.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_index             = CFG_KEY_TEXT;
    cfg_data              = '0;
    in_chan.valid         = 1'b0;
    in_chan.byte_in       = 8'h00;
    in_chan.end_of_string = 1'b0;
    key_text_sh           = '0;
    key_len_sh            = '0;
    limit_sh              = VALUE_LIMIT_RST;
    clear_scan();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_key_edges();
    test_limit_extremes();
    test_limit_lowered();
    test_backpressure();
    test_random_queries();

    wait_idle();
    if (err_count == 0 && results_owed.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/qaud_pkg.sv
rtl/qaud_if.sv
rtl/query_arg_extract_url_decode_unit.sv
tb/tb.sv
